>>> rtl/agps_pkg.sv
// Shared types and constants for the aging green phase scheduler.
`timescale 1ns / 1ps

package agps_pkg;

	localparam int LANE_W  = 3;
	localparam int COUNT_W = 16;
	localparam int DUR_W   = 8;
	localparam int USE_W   = 4;
	localparam int CFG_W   = 16;
	localparam int SCORE_W = COUNT_W + 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_ARRIVAL = 1'b1;

	typedef enum logic [1:0] {
		CFG_GREEN_DURATION       = 2'd0,
		CFG_STARVATION_THRESHOLD = 2'd1,
		CFG_LANES_IN_USE         = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic              command;
		logic [LANE_W-1:0] lane;
	} in_t;

	typedef struct packed {
		logic               green_valid;
		logic [LANE_W-1:0]  green_lane;
		logic [DUR_W-1:0]   green_time_left;
		logic               switched;
		logic               by_starvation;
		logic [COUNT_W-1:0] green_queue;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic scan;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/agps_ctrl.sv
// Sequencing state machine for the scheduler: accept, lane scan, commit.
`timescale 1ns / 1ps

module agps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           command,
	output logic           in_ready,
	input  agps_pkg::stat_t stat,
	output agps_pkg::ctl_t  ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign ctl.capture = (state_q == ST_IDLE) && in_valid;
	assign ctl.scan    = (state_q == ST_SCAN);
	assign ctl.finish  = (state_q == ST_FINISH) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (command == agps_pkg::CMD_ARRIVAL) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.scan_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/agps_datapath.sv
// Lane counters, configuration registers, scoring unit and result register.
`timescale 1ns / 1ps

module agps_datapath #(
	parameter int LANES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [agps_pkg::CFG_W-1:0]        cfg_data,
	input  agps_pkg::in_t                     in_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output agps_pkg::out_t                    out_data,
	input  agps_pkg::ctl_t                    ctl,
	output agps_pkg::stat_t                   stat
);

	localparam int NL    = (LANES > 8) ? 8 : LANES;
	localparam int IDX_W = $clog2(NL);
	localparam int CW    = agps_pkg::COUNT_W;
	localparam int LW    = agps_pkg::LANE_W;
	localparam int DW    = agps_pkg::DUR_W;
	localparam int UW    = agps_pkg::USE_W;
	localparam int SW    = agps_pkg::SCORE_W;

	// configuration
	logic [DW-1:0] dur_q;
	logic [CW-1:0] thr_q;
	logic [UW-1:0] use_q;

	// per-lane state
	logic [CW-1:0] queue_q [NL];
	logic [CW-1:0] wait_q  [NL];
	logic [CW-1:0] worst_q [NL];

	// green phase
	logic          holds_q;
	logic [LW-1:0] gidx_q;
	logic [DW-1:0] timer_q;
	logic [CW-1:0] gq_q;

	// transaction and scan registers
	logic          cmd_q;
	logic [LW-1:0] lane_q;
	logic [IDX_W-1:0] idx_q;
	logic          found_q;
	logic [IDX_W-1:0] sel_q;
	logic [SW-1:0] best_q;
	logic [CW-1:0] cand_q;

	logic          out_valid_q;
	agps_pkg::out_t out_q;

	logic [UW-1:0]    n_eff;
	logic [IDX_W-1:0] rd_addr;
	logic [CW-1:0]    q_rd;
	logic [CW-1:0]    w_rd;
	logic             green_here;
	logic [CW-1:0]    wait_new;
	logic [SW-1:0]    score;
	logic             thr_hit;
	logic             is_tick;
	logic             take;
	logic             arr_ok;
	logic             arr_inc;
	logic [DW-1:0]    t_load;
	logic             holds_n;
	logic [LW-1:0]    gidx_n;
	logic [DW-1:0]    timer_n;
	logic [CW-1:0]    gq_n;

	always_comb begin
		if (use_q == '0) begin
			n_eff = UW'(1);
		end else if (use_q > UW'(NL)) begin
			n_eff = UW'(NL);
		end else begin
			n_eff = use_q;
		end
	end

	assign rd_addr    = ctl.scan ? idx_q : lane_q[IDX_W-1:0];
	assign q_rd       = queue_q[rd_addr];
	assign w_rd       = wait_q[idx_q];
	assign green_here = holds_q && (gidx_q == LW'(idx_q));
	assign wait_new   = green_here ? '0 :
	                    ((w_rd == agps_pkg::COUNT_MAX) ? w_rd : w_rd + CW'(1));
	assign score      = (SW'(q_rd) << 1) + SW'(wait_new);
	assign thr_hit    = (wait_new >= thr_q);

	assign stat.scan_last = (UW'(idx_q) == n_eff - UW'(1));
	assign stat.out_free  = !out_valid_q || out_ready;

	// commit of a finished transaction
	assign is_tick = (cmd_q == agps_pkg::CMD_TICK);
	assign take    = is_tick && !(holds_q && (timer_q != '0));
	assign arr_ok  = !is_tick && ({1'b0, lane_q} < n_eff);
	assign arr_inc = arr_ok && (q_rd != agps_pkg::COUNT_MAX);
	assign t_load  = take ? dur_q : timer_q;

	always_comb begin
		holds_n = take ? 1'b1 : holds_q;
		gidx_n  = take ? LW'(sel_q) : gidx_q;
		if (!is_tick) begin
			timer_n = timer_q;
		end else if (t_load != '0) begin
			timer_n = t_load - DW'(1);
		end else begin
			timer_n = '0;
		end
		if (take) begin
			gq_n = cand_q;
		end else if (arr_inc && holds_q && (gidx_q == lane_q)) begin
			gq_n = q_rd + CW'(1);
		end else begin
			gq_n = gq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= DW'(5);
			thr_q <= CW'(15);
			use_q <= UW'(5);
		end else if (cfg_we) begin
			case (cfg_index)
				agps_pkg::CFG_GREEN_DURATION:       dur_q <= cfg_data[DW-1:0];
				agps_pkg::CFG_STARVATION_THRESHOLD: thr_q <= cfg_data[CW-1:0];
				agps_pkg::CFG_LANES_IN_USE:         use_q <= cfg_data[UW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++) begin
				queue_q[i] <= '0;
				wait_q[i]  <= '0;
				worst_q[i] <= '0;
			end
		end else begin
			if (ctl.scan) begin
				wait_q[idx_q] <= wait_new;
				if (!green_here && (wait_new > worst_q[idx_q])) begin
					worst_q[idx_q] <= wait_new;
				end
			end
			if (ctl.finish && take) begin
				wait_q[sel_q] <= '0;
			end
			if (ctl.finish && arr_inc) begin
				queue_q[lane_q[IDX_W-1:0]] <= q_rd + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holds_q <= 1'b0;
			gidx_q  <= '0;
			timer_q <= '0;
			gq_q    <= '0;
		end else if (ctl.finish) begin
			holds_q <= holds_n;
			gidx_q  <= gidx_n;
			timer_q <= timer_n;
			gq_q    <= gq_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= in_data.command;
			lane_q  <= in_data.lane;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.scan) begin
			idx_q <= idx_q + IDX_W'(1);
			if (!found_q) begin
				if (thr_hit) begin
					found_q <= 1'b1;
					sel_q   <= idx_q;
					cand_q  <= q_rd;
				end else if ((idx_q == '0) || (score > best_q)) begin
					best_q <= score;
					sel_q  <= idx_q;
					cand_q <= q_rd;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			out_q.green_valid     <= holds_n;
			out_q.green_lane      <= holds_n ? gidx_n : '0;
			out_q.green_time_left <= timer_n;
			out_q.switched        <= take;
			out_q.by_starvation   <= take && found_q;
			out_q.green_queue     <= holds_n ? gq_n : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_timer_needs_green: assert property (@(posedge clk) disable iff (!arst_n)
		!holds_q |-> (timer_q == '0))
		else $error("green timer running without a green lane");

	a_green_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		holds_q |-> ({1'b0, gidx_q} < (LW+1)'(NL)))
		else $error("green lane index beyond lane storage");

	a_green_queue_track: assert property (@(posedge clk) disable iff (!arst_n)
		holds_q |-> (gq_q == queue_q[gidx_q[IDX_W-1:0]]))
		else $error("green queue copy out of step with lane queue");

	a_starve_implies_switch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.by_starvation) |-> out_q.switched)
		else $error("starvation flag without a switch");
`endif

endmodule

>>> rtl/aging_green_phase_scheduler.sv
// Top level of the aging green phase scheduler.
`timescale 1ns / 1ps

// Usage:
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 green
//   duration, 1 starvation threshold, 2 lanes in use); write only while idle.
//   Input channel in_valid/in_ready carries one transaction: a tick or an
//   arrival at a lane. Output channel out_valid/out_ready returns one result
//   transaction per input with the green lane, its timer and queue, and the
//   switch flags.
//   An arrival goes from acceptance straight to the commit step; a tick first
//   scans the n lanes in use (1..8), one lane per cycle through a single
//   scoring unit, and then commits. The commit step loads the output register.
//   One transaction is in flight at a time: a new input is taken only once
//   the previous one has committed its result.
//   The result sits in an output register: a new input is accepted while it
//   waits; if the receiver stalls, the next result waits in its final step
//   and no further input is taken.
//   Reset clears all queues, waits and the green phase, and loads the
//   register defaults (duration 5, threshold 15, five lanes).
module aging_green_phase_scheduler #(
	parameter int LANES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [agps_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  agps_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output agps_pkg::out_t             out_data
);

	agps_pkg::ctl_t  ctl;
	agps_pkg::stat_t stat;

	agps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (in_data.command),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	agps_datapath #(
		.LANES (LANES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.ctl       (ctl),
		.stat      (stat)
	);

endmodule

>>> tb/tb_aging_green_phase_scheduler.sv
// Self-checking testbench for the aging green phase scheduler.
`timescale 1ns / 1ps

module tb_aging_green_phase_scheduler;

	localparam int LANES         = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_OFF      = 200;
	localparam int SETTLE_CYCLES = 12;
	localparam int TAIL_CYCLES   = 20;
	localparam int RAND_PHASES   = 13;
	localparam int PHASE_ITEMS   = 120;
	localparam int RUSH_ITEMS    = 32;

	class phase_board;
		logic [agps_pkg::DUR_W-1:0]   dur_reg;
		logic [agps_pkg::COUNT_W-1:0] thr_reg;
		logic [agps_pkg::USE_W-1:0]   use_reg;
		logic [agps_pkg::COUNT_W-1:0] lane_queue [LANES];
		logic [agps_pkg::COUNT_W-1:0] lane_wait [LANES];
		logic [agps_pkg::COUNT_W-1:0] lane_worst [LANES];
		logic                         green_on;
		logic [agps_pkg::LANE_W-1:0]  green_at;
		logic [agps_pkg::DUR_W-1:0]   phase_left;
		agps_pkg::out_t               grants_due [$];
		int                           errors;

		function new();
			dur_reg = 8'd5;
			thr_reg = 16'd15;
			use_reg = 4'd5;
			foreach (lane_queue[i]) begin
				lane_queue[i] = '0;
				lane_wait[i]  = '0;
				lane_worst[i] = '0;
			end
			green_on   = 1'b0;
			green_at   = '0;
			phase_left = '0;
			errors     = 0;
		endfunction

		function void set_reg(agps_pkg::cfg_index_t idx, logic [agps_pkg::CFG_W-1:0] value);
			case (idx)
				agps_pkg::CFG_GREEN_DURATION:       dur_reg = value[agps_pkg::DUR_W-1:0];
				agps_pkg::CFG_STARVATION_THRESHOLD: thr_reg = value[agps_pkg::COUNT_W-1:0];
				agps_pkg::CFG_LANES_IN_USE:         use_reg = value[agps_pkg::USE_W-1:0];
				default: ;
			endcase
		endfunction

		function int lanes_active();
			int n;
			n = int'(use_reg);
			if (n == 0)
				n = 1;
			if (n > LANES)
				n = LANES;
			return n;
		endfunction

		function int pending();
			return grants_due.size();
		endfunction

		function void note_request(agps_pkg::in_t item);
			int             n;
			int             sel;
			bit             found;
			bit             sw;
			int unsigned    best;
			int unsigned    score;
			agps_pkg::out_t grant;
			n     = lanes_active();
			sel   = 0;
			found = 1'b0;
			sw    = 1'b0;
			if (item.command == agps_pkg::CMD_ARRIVAL) begin
				if (int'(item.lane) < n && lane_queue[item.lane] != agps_pkg::COUNT_MAX)
					lane_queue[item.lane]++;
			end else begin
				for (int i = 0; i < n; i++) begin
					if (!(green_on && int'(green_at) == i)) begin
						if (lane_wait[i] != agps_pkg::COUNT_MAX)
							lane_wait[i]++;
						if (lane_wait[i] > lane_worst[i])
							lane_worst[i] = lane_wait[i];
					end else begin
						lane_wait[i] = '0;
					end
				end
				if (!(green_on && phase_left != 0)) begin
					for (int i = 0; i < n; i++) begin
						if (!found && lane_wait[i] >= thr_reg) begin
							sel   = i;
							found = 1'b1;
						end
					end
					if (!found) begin
						best = 0;
						for (int i = 0; i < n; i++) begin
							score = 2 * int'(lane_queue[i]) + int'(lane_wait[i]);
							if (i == 0 || score > best) begin
								best = score;
								sel  = i;
							end
						end
					end
					green_on       = 1'b1;
					green_at       = agps_pkg::LANE_W'(sel);
					phase_left     = dur_reg;
					lane_wait[sel] = '0;
					sw             = 1'b1;
				end
				if (green_on && phase_left != 0)
					phase_left--;
			end
			grant.green_valid     = green_on;
			grant.green_lane      = green_on ? green_at : '0;
			grant.green_time_left = phase_left;
			grant.switched        = sw;
			grant.by_starvation   = found;
			grant.green_queue     = green_on ? lane_queue[green_at] : '0;
			grants_due = {grants_due, grant};
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_grant(agps_pkg::out_t got);
			agps_pkg::out_t want;
			if (grants_due.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = grants_due.pop_front();
			compare_field("green_valid", 32'(want.green_valid), 32'(got.green_valid));
			compare_field("green_lane", 32'(want.green_lane), 32'(got.green_lane));
			compare_field("green_time_left", 32'(want.green_time_left),
				32'(got.green_time_left));
			compare_field("switched", 32'(want.switched), 32'(got.switched));
			compare_field("by_starvation", 32'(want.by_starvation), 32'(got.by_starvation));
			compare_field("green_queue", 32'(want.green_queue), 32'(got.green_queue));
		endfunction
	endclass

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [1:0]                 cfg_index = '0;
	logic [agps_pkg::CFG_W-1:0] cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	agps_pkg::in_t              in_data   = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	agps_pkg::out_t             out_data;

	phase_board sb;
	bit         rush      = 1'b0;
	bit         send_calm = 1'b0;
	int         sent      = 0;

	aging_green_phase_scheduler #(
		.LANES(LANES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_gap(bit calm);
		if (calm || rush)
			return 0;
		return $urandom_range(0, 4);
	endfunction

	function automatic agps_pkg::in_t item_of(logic cmd,
		logic [agps_pkg::LANE_W-1:0] lane_no);
		agps_pkg::in_t t;
		t.command = cmd;
		t.lane    = lane_no;
		return t;
	endfunction

	task automatic send_item(input agps_pkg::in_t item);
		int gap;
		sent++;
		if (sent % 50 == 0)
			send_calm = ($urandom_range(0, 2) == 0);
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(item);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input agps_pkg::cfg_index_t idx,
		input logic [agps_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	initial begin : receiver
		int stall_left;
		int results;
		bit calm;
		stall_left = 0;
		results    = 0;
		calm       = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_grant(out_data);
				results++;
				if (results % 50 == 0)
					calm = ($urandom_range(0, 2) == 0);
				if (results == 300 || results == 1000 || results == 1500)
					stall_left = HOLD_OFF;
				else
					stall_left = draw_gap(calm);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int                           n;
		logic [agps_pkg::DUR_W-1:0]   dur_v;
		logic [agps_pkg::COUNT_W-1:0] thr_v;
		logic [agps_pkg::USE_W-1:0]   use_v;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first pick from all-zero state, arrivals on used and unused lanes
		send_item(item_of(agps_pkg::CMD_TICK, 3'd5));
		for (int l = 0; l < LANES; l++)
			send_item(item_of(agps_pkg::CMD_ARRIVAL, agps_pkg::LANE_W'(l)));
		send_item(item_of(agps_pkg::CMD_ARRIVAL, 3'd2));
		send_item(item_of(agps_pkg::CMD_ARRIVAL, 3'd2));
		repeat (6) send_item(item_of(agps_pkg::CMD_TICK, 3'd7));

		// zero duration, zero threshold, lane count of zero
		settle();
		write_reg(agps_pkg::CFG_GREEN_DURATION, 16'd0);
		write_reg(agps_pkg::CFG_STARVATION_THRESHOLD, 16'd0);
		write_reg(agps_pkg::CFG_LANES_IN_USE, 16'd0);
		repeat (3) send_item(item_of(agps_pkg::CMD_TICK, 3'd0));

		// lane count above range, longest duration, highest threshold
		settle();
		write_reg(agps_pkg::CFG_LANES_IN_USE, 16'd15);
		write_reg(agps_pkg::CFG_GREEN_DURATION, 16'd255);
		write_reg(agps_pkg::CFG_STARVATION_THRESHOLD, 16'hFFFF);
		repeat (4) send_item(item_of(agps_pkg::CMD_ARRIVAL, 3'd7));
		send_item(item_of(agps_pkg::CMD_TICK, 3'd1));

		// green lane dropped from use keeps its phase
		settle();
		write_reg(agps_pkg::CFG_LANES_IN_USE, 16'd2);
		send_item(item_of(agps_pkg::CMD_ARRIVAL, 3'd7));
		repeat (2) send_item(item_of(agps_pkg::CMD_TICK, 3'd3));

		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			case ($urandom_range(0, 4))
				0: dur_v = 8'd0;
				1: dur_v = 8'd1;
				2: dur_v = 8'd255;
				default: dur_v = agps_pkg::DUR_W'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 4))
				0: thr_v = 16'd0;
				1: thr_v = 16'hFFFF;
				2: thr_v = agps_pkg::COUNT_W'($urandom_range(0, 65535));
				default: thr_v = agps_pkg::COUNT_W'($urandom_range(1, 40));
			endcase
			case ($urandom_range(0, 5))
				0: use_v = 4'd0;
				1: use_v = agps_pkg::USE_W'($urandom_range(9, 15));
				default: use_v = agps_pkg::USE_W'($urandom_range(1, LANES));
			endcase
			write_reg(agps_pkg::CFG_GREEN_DURATION, {8'($urandom), dur_v});
			write_reg(agps_pkg::CFG_STARVATION_THRESHOLD, thr_v);
			write_reg(agps_pkg::CFG_LANES_IN_USE, {12'($urandom), use_v});
			n = sb.lanes_active();
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 40)
					send_item(item_of(agps_pkg::CMD_TICK, 3'($urandom)));
				else if ($urandom_range(0, 9) < 8)
					send_item(item_of(agps_pkg::CMD_ARRIVAL, 3'($urandom_range(0, n - 1))));
				else
					send_item(item_of(agps_pkg::CMD_ARRIVAL, 3'($urandom)));
			end
		end

		// back-to-back burst: lane 0 arrivals, then ticks
		settle();
		write_reg(agps_pkg::CFG_LANES_IN_USE, 16'd2);
		write_reg(agps_pkg::CFG_STARVATION_THRESHOLD, 16'hFFFF);
		write_reg(agps_pkg::CFG_GREEN_DURATION, 16'd255);
		rush = 1'b1;
		repeat (RUSH_ITEMS) send_item(item_of(agps_pkg::CMD_ARRIVAL, 3'd0));
		repeat (RUSH_ITEMS) send_item(item_of(agps_pkg::CMD_TICK, 3'($urandom)));
		rush = 1'b0;

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
